### sv/crtls_pkg.sv
// Shared types, constants and register mask table for the CRT line sequencer.
package crtls_pkg;

	// Default size of the controller register file
	localparam int REGISTER_COUNT_DEF = 18;

	// Request kinds carried in tuser
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Port offsets decoded on reads; writes use offsets up to PORT_WR_LAST
	localparam logic [3:0] PORT_INDEX  = 4'd4;
	localparam logic [3:0] PORT_DATA   = 4'd5;
	localparam logic [3:0] PORT_STATUS = 4'd10;
	localparam logic [3:0] PORT_WR_LAST = 4'd7;

	// Controller register numbers used by the sequencer
	localparam int R_H_DISPLAYED = 1;
	localparam int R_V_TOTAL     = 4;
	localparam int R_V_ADJUST    = 5;
	localparam int R_V_DISPLAYED = 6;
	localparam int R_V_SYNC_POS  = 7;
	localparam int R_INTERLACE   = 8;
	localparam int R_MAX_SCAN    = 9;
	localparam int R_CURSOR_ST   = 10;
	localparam int R_CURSOR_END  = 11;
	localparam int R_START_HI    = 12;
	localparam int R_START_LO    = 13;

	// Read value for unmapped ports
	localparam logic [7:0] RD_UNMAPPED = 8'hff;
	// Retrace countdown length in line-start ticks
	localparam logic [4:0] VSYNC_LINES = 5'd16;

	// Register values the sequencer needs
	typedef struct packed {
		logic [7:0] h_displayed;
		logic [7:0] v_total;
		logic [7:0] v_adjust;
		logic [7:0] v_displayed;
		logic [7:0] v_sync_pos;
		logic [7:0] interlace;
		logic [7:0] max_scan;
		logic [7:0] cursor_start;
		logic [7:0] cursor_end;
		logic [7:0] start_hi;
		logic [7:0] start_lo;
	} crtls_regs_t;

	// Register file write request
	typedef struct packed {
		logic       index_wr;
		logic       data_wr;
		logic [7:0] wdata;
	} crtls_bus_t;

	// Sequencer state as seen after the current request
	typedef struct packed {
		logic        display_on;
		logic [14:0] line_address;
		logic [4:0]  line_row;
		logic        cursor_shown;
		logic        vsync;
		logic        in_blank;
		logic [3:0]  status;
	} crtls_view_t;

	// Writable bits of each controller register
	function automatic logic [7:0] reg_mask(input logic [4:0] idx);
		logic [7:0] m;
		case (idx)
			5'd0, 5'd1, 5'd2, 5'd3: m = 8'hff;
			5'd4:  m = 8'h7f;
			5'd5:  m = 8'h1f;
			5'd6:  m = 8'h7f;
			5'd7:  m = 8'h7f;
			5'd8:  m = 8'hf3;
			5'd9:  m = 8'h1f;
			5'd10: m = 8'h7f;
			5'd11: m = 8'h1f;
			5'd12: m = 8'h3f;
			5'd13: m = 8'hff;
			5'd14: m = 8'h3f;
			5'd15, 5'd16, 5'd17: m = 8'hff;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

endpackage

### sv/crtls_regfile.sv
// Controller register file with index register and masked data writes.
module crtls_regfile #(
	parameter int REGISTER_COUNT = crtls_pkg::REGISTER_COUNT_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  crtls_pkg::crtls_bus_t   bus,
	output logic [4:0]              reg_index,
	output logic [7:0]              rd_data,
	output crtls_pkg::crtls_regs_t  regs
);
	import crtls_pkg::*;

	localparam int IDX_W = $clog2(REGISTER_COUNT);
	localparam logic [5:0] COUNT_C = 6'(REGISTER_COUNT);

	logic [7:0] regs_q [REGISTER_COUNT];
	logic [4:0] index_q;
	logic       in_file;

	assign in_file = {1'b0, index_q} < COUNT_C;

	// Index and data writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			for (int i = 0; i < REGISTER_COUNT; i++) begin
				regs_q[i] <= '0;
			end
		end else begin
			if (bus.index_wr) begin
				index_q <= bus.wdata[4:0];
			end
			if (bus.data_wr && in_file) begin
				regs_q[index_q[IDX_W-1:0]] <= bus.wdata & reg_mask(index_q);
			end
		end
	end

	assign reg_index = index_q;
	assign rd_data   = in_file ? regs_q[index_q[IDX_W-1:0]] : 8'h00;

	// Fixed taps for the sequencer
	assign regs.h_displayed  = regs_q[R_H_DISPLAYED];
	assign regs.v_total      = regs_q[R_V_TOTAL];
	assign regs.v_adjust     = regs_q[R_V_ADJUST];
	assign regs.v_displayed  = regs_q[R_V_DISPLAYED];
	assign regs.v_sync_pos   = regs_q[R_V_SYNC_POS];
	assign regs.interlace    = regs_q[R_INTERLACE];
	assign regs.max_scan     = regs_q[R_MAX_SCAN];
	assign regs.cursor_start = regs_q[R_CURSOR_ST];
	assign regs.cursor_end   = regs_q[R_CURSOR_END];
	assign regs.start_hi     = regs_q[R_START_HI];
	assign regs.start_lo     = regs_q[R_START_LO];

endmodule

### sv/crtls_seq.sv
// Scan-line sequencer: line-end and line-start tick handling and status bits.
module crtls_seq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    tick,
	input  crtls_pkg::crtls_regs_t  regs,
	output crtls_pkg::crtls_view_t  view
);
	import crtls_pkg::*;

	logic        half_q, cro_q, cbo_q, fo_q, vd_q;
	logic [4:0]  sr_q, al_q, vl_q;
	logic [6:0]  rc_q;
	logic [14:0] ca_q, rsa_q;
	logic [3:0]  bc_q, sb_q;

	logic        half_d, cro_d, cbo_d, fo_d, vd_d;
	logic [4:0]  sr_d, al_d, vl_d;
	logic [6:0]  rc_d;
	logic [14:0] ca_d, rsa_d;
	logic [3:0]  bc_d, sb_d;
	logic [14:0] addr_out;
	logic [4:0]  row_out;

	logic        il;
	logic [4:0]  ce, cs;
	logic [14:0] start_addr;

	assign il         = regs.interlace[1:0] == 2'b11;
	assign ce         = regs.cursor_end[4:0];
	assign cs         = regs.cursor_start[4:0];
	assign start_addr = {regs.start_hi[6:0], regs.start_lo};

	// Next state for one tick
	always_comb begin
		half_d = half_q; cro_d = cro_q; cbo_d = cbo_q; fo_d = fo_q; vd_d = vd_q;
		sr_d = sr_q; al_d = al_q; vl_d = vl_q; rc_d = rc_q;
		ca_d = ca_q; rsa_d = rsa_q; bc_d = bc_q; sb_d = sb_q;
		addr_out = '0;
		row_out  = '0;

		if (tick) begin
			if (!half_q) begin
				// line end: horizontal blank, retrace start, address advance
				half_d   = 1'b1;
				sb_d[0]  = 1'b1;
				row_out  = il ? {2'b00, sr_q[1:0], fo_q} : sr_q;
				if ({1'b0, rc_q} == regs.v_sync_pos && sr_q == 5'd0) begin
					sb_d[3] = 1'b1;
				end
				addr_out = ca_q;
				if (vd_q) begin
					ca_d = ca_q + 15'(regs.h_displayed);
				end
			end else begin
				// line start
				half_d = 1'b0;
				if (vl_q != 5'd0) begin
					vl_d = vl_q - 5'd1;
					if (vl_d == 5'd0) begin
						sb_d[3] = 1'b0;
					end
				end
				if (sr_q == ce || (il && sr_q == {1'b0, ce[4:1]})) begin
					cro_d = 1'b0;
				end
				if (il && {3'b000, sr_q} == {1'b0, regs.max_scan[7:1]}) begin
					rsa_d = ca_q;
				end
				if (al_q != 5'd0) begin
					// vertical adjust lines
					sr_d = sr_q + 5'd1;
					ca_d = rsa_d;
					al_d = al_q - 5'd1;
					if (al_d == 5'd0) begin
						vd_d  = 1'b1;
						ca_d  = start_addr;
						rsa_d = start_addr;
						sr_d  = 5'd0;
					end
				end else if ({3'b000, sr_q} == regs.max_scan) begin
					// last scan row of a character row
					rsa_d = ca_q;
					sr_d  = 5'd0;
					rc_d  = rc_q + 7'd1;
					if ({1'b0, rc_d} == regs.v_displayed) begin
						vd_d = 1'b0;
					end
					if ({1'b0, rc_q} == regs.v_total) begin
						rc_d = 7'd0;
						al_d = regs.v_adjust[4:0];
						if (al_d == 5'd0) begin
							vd_d  = 1'b1;
							ca_d  = start_addr;
							rsa_d = start_addr;
						end
						if (regs.cursor_start[6:5] == 2'b01) begin
							cbo_d = 1'b0;
						end else begin
							cbo_d = bc_q[3];
						end
					end
					if ({1'b0, rc_d} == regs.v_sync_pos) begin
						vd_d = 1'b0;
						vl_d = VSYNC_LINES;
						bc_d = bc_q + 4'd1;
						fo_d = ~fo_q;
					end
				end else begin
					sr_d = sr_q + 5'd1;
					ca_d = rsa_d;
				end
				if (vd_d) begin
					sb_d[0] = 1'b0;
				end
				if (sr_d == cs || (il && sr_d == {1'b0, cs[4:1]})) begin
					cro_d = 1'b1;
				end
			end
		end

		if (!(tick && !half_q)) begin
			addr_out = ca_d;
			row_out  = sr_d;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= 1'b0; cro_q <= 1'b0; cbo_q <= 1'b0; fo_q <= 1'b0; vd_q <= 1'b0;
			sr_q <= '0; al_q <= '0; vl_q <= '0; rc_q <= '0;
			ca_q <= '0; rsa_q <= '0; bc_q <= '0; sb_q <= '0;
		end else begin
			half_q <= half_d; cro_q <= cro_d; cbo_q <= cbo_d; fo_q <= fo_d; vd_q <= vd_d;
			sr_q <= sr_d; al_q <= al_d; vl_q <= vl_d; rc_q <= rc_d;
			ca_q <= ca_d; rsa_q <= rsa_d; bc_q <= bc_d; sb_q <= sb_d;
		end
	end

	assign view.display_on   = vd_d;
	assign view.line_address = addr_out;
	assign view.line_row     = row_out;
	assign view.cursor_shown = cro_d & cbo_d;
	assign view.vsync        = sb_d[3];
	assign view.in_blank     = half_d;
	assign view.status       = sb_q;

endmodule

### sv/crt_controller_line_sequencer_top.sv
// Top level of the CRT controller line sequencer.
// Usage:
//   Requests enter on the s_ group: s_tuser holds the kind (half-line tick,
//   port write or port read), s_tdata holds the port offset and write byte.
//   Every request yields exactly one result on the m_ group: read data plus
//   the display, line address, scan row, cursor, retrace and blank flags as
//   they stand after the request.
//   A request is taken into an input register, processed by combinational
//   logic and stored in the output register, from which m_tvalid is driven.
//   One request per cycle is sustained while m_tready stays high.
//   When the receiver stalls, the result holds in the output register and
//   one more request waits in the input register; s_tready then drops until
//   m_tready returns.
//   Reset clears the register file, the index, all counters and status bits,
//   and empties both registers.
module crt_controller_line_sequencer_top #(
	parameter int REGISTER_COUNT = crtls_pkg::REGISTER_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [3:0] port, [11:4] wdata, [15:12] zero
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [7:0] read_data, [8] display_on,
	                               // [23:9] line_address, [28:24] line_row,
	                               // [29] cursor_shown, [30] vsync_flag,
	                               // [31] in_blank
);
	import crtls_pkg::*;

	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [3:0]  port_s1;
	logic [7:0]  wdata_s1;
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        adv;

	crtls_bus_t  bus;
	crtls_regs_t regs;
	crtls_view_t view;
	logic [4:0]  reg_index;
	logic [7:0]  rd_data;
	logic [7:0]  read_data;
	logic        is_wr;

	// Flow control
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || !out_valid_q || m_tready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1  <= s_tuser;
			port_s1  <= s_tdata[3:0];
			wdata_s1 <= s_tdata[11:4];
		end
	end

	// Port write decode
	assign is_wr        = adv && kind_s1 == KIND_WRITE && port_s1 <= PORT_WR_LAST;
	assign bus.index_wr = is_wr && !port_s1[0];
	assign bus.data_wr  = is_wr && port_s1[0];
	assign bus.wdata    = wdata_s1;

	crtls_regfile #(
		.REGISTER_COUNT(REGISTER_COUNT)
	) u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.bus       (bus),
		.reg_index (reg_index),
		.rd_data   (rd_data),
		.regs      (regs)
	);

	crtls_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (adv && kind_s1 == KIND_TICK),
		.regs   (regs),
		.view   (view)
	);

	// Port read decode
	always_comb begin
		read_data = 8'h00;
		if (kind_s1 == KIND_READ) begin
			case (port_s1)
				PORT_INDEX:  read_data = {3'b000, reg_index};
				PORT_DATA:   read_data = rd_data;
				PORT_STATUS: read_data = {4'h0, view.status};
				default:     read_data = RD_UNMAPPED;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {view.in_blank, view.vsync, view.cursor_shown, view.line_row,
				view.line_address, view.display_on, read_data};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
